/* rtl/ungapped_seed_extension_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the ungapped seed extension block
// Short forms for clocked assertions on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef UNGAPPED_SEED_EXTENSION_ASSERT_SVH
`define UNGAPPED_SEED_EXTENSION_ASSERT_SVH

// A condition that holds at every clock edge.
`define UNGX_ASSERT_HOLDS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A condition that holds in the same cycle as its trigger.
`define UNGX_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// A condition that holds in the cycle after its trigger.
`define UNGX_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/ungx_pkg.sv */
// ----------------------------------------------------------------------------
// Ungapped seed extension package
// Widths, symbol codes, request modes and the state and result records.
// ----------------------------------------------------------------------------
package ungx_pkg;

   // Field widths.
   localparam int OFFSET_BITS = 20;
   localparam int SCORE_BITS  = 24;
   localparam int RUN_BITS    = 26;
   localparam int COUNT_BITS  = 21;
   localparam int SEED_BITS   = 8;
   localparam int SYM_BITS    = 8;
   localparam int MODE_BITS   = 2;

   // Scoring: a match is worth POINT, which is a shift by POINT_SHIFT.
   localparam int POINT       = 4;
   localparam int POINT_SHIFT = 2;

   // Special symbols.
   localparam logic [SYM_BITS-1:0] SYM_SEP = 8'd42;
   localparam logic [SYM_BITS-1:0] SYM_UNK = 8'd78;

   // Saturation limits.
   localparam logic [SCORE_BITS-1:0]  SCORE_MAX  = '1;
   localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = '1;
   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

   // Request channel packing.
   localparam int REQ_DATA_BITS = 2 * SYM_BITS;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_SEED   = 2'd0,
      MODE_FWD    = 2'd1,
      MODE_BWD    = 2'd2,
      MODE_FINISH = 2'd3
   } mode_type;

   // Extension state carried from one request to the next.
   typedef struct packed {
      logic signed [RUN_BITS-1:0] running_score;
      logic [SCORE_BITS-1:0]      peak_score;
      logic [COUNT_BITS-1:0]      match_count;
      logic [COUNT_BITS-1:0]      peak_match_count;
      logic [OFFSET_BITS-1:0]     step_count;
      logic [OFFSET_BITS-1:0]     best_end;
      logic [OFFSET_BITS-1:0]     best_start;
      logic                       direction_stopped;
      logic                       in_backward;
   } ext_state_type;

   // Reported fragment, first field in the highest bits.
   typedef struct packed {
      logic [COUNT_BITS-1:0]  identities;
      logic [SCORE_BITS-1:0]  best_score;
      logic [OFFSET_BITS:0]   fragment_length;
      logic [OFFSET_BITS-1:0] start_offset;
      logic [OFFSET_BITS-1:0] end_offset;
   } rsp_payload_type;

   localparam int RSP_BITS      = $bits(rsp_payload_type);
   localparam int RSP_DATA_BITS = ((RSP_BITS + 7) / 8) * 8;

   // Clamp a sum that may have carried one bit past the offset width.
   function automatic logic [OFFSET_BITS-1:0] sat_offset(input logic [OFFSET_BITS:0] value);
      logic [OFFSET_BITS-1:0] result;
      result = value[OFFSET_BITS] ? OFFSET_MAX : value[OFFSET_BITS-1:0];
      return result;
   endfunction

endpackage

/* rtl/ungapped_seed_extension.sv */
// ----------------------------------------------------------------------------
// Ungapped seed extension
// Extends a seed hit along its diagonal and reports the best fragment.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the req_ stream: tuser carries the mode (seed start,
//   forward pair, backward pair, finish) and tdata the two symbol bytes.
//   A seed request opens an extension, forward pairs follow, then backward
//   pairs, and a finish request emits one fragment on the rsp_ stream.
//   Other requests produce no response.
//   The user must write the seed length register over the csr_ channel only
//   while no request is in flight; the block itself does not enforce it.
//   Each request is registered on entry and scored from the request register;
//   a finish response is loaded into the response register as it leaves.
//   One request is accepted every cycle unless a finish is held back; the
//   score update is one add and compare between request and state registers.
//   When the receiver stalls, a held response does not block pairs; only a
//   second finish waits in the request register until the response is taken.
//   Reset clears all extension state and sets the seed length to 12.
// ----------------------------------------------------------------------------
`include "ungapped_seed_extension_assert.svh"

module ungapped_seed_extension (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [ungx_pkg::REQ_DATA_BITS-1:0]   req_tdata,  // symbol_x, symbol_y
   input  logic [ungx_pkg::MODE_BITS-1:0]       req_tuser,  // mode
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // end_offset, start_offset, fragment_length, best_score, identities
   output logic [ungx_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ungx_pkg::SEED_BITS-1:0]       csr_data
);
   import ungx_pkg::*;

   logic                   in_valid_ff;
   logic                   in_valid_in;
   mode_type               in_mode_ff;
   logic [SYM_BITS-1:0]    in_sx_ff;
   logic [SYM_BITS-1:0]    in_sy_ff;
   ext_state_type          state_ff;
   ext_state_type          state_in;
   ext_state_type          state_in_step;
   logic [SEED_BITS-1:0]   seed_length_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   rsp_payload_type        rsp_payload_ff;
   rsp_payload_type        report;
   logic                   req_take;
   logic                   advance;
   logic                   rsp_load;

   // Handshake control: only a finish behind a stalled response waits.
   always_comb begin
      advance      = !(in_valid_ff && (in_mode_ff == MODE_FINISH) &&
                       rsp_valid_ff && !rsp_tready);
      req_tready   = !in_valid_ff || advance;
      req_take     = req_tvalid && req_tready;
      in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      rsp_load     = in_valid_ff && advance && (in_mode_ff == MODE_FINISH);
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      state_in     = (in_valid_ff && advance) ? state_in_step : state_ff;
   end

   ungx_step u_step (
      .state_cur   (state_ff),
      .mode        (in_mode_ff),
      .symbol_x    (in_sx_ff),
      .symbol_y    (in_sy_ff),
      .seed_length (seed_length_ff),
      .state_nxt   (state_in_step),
      .report      (report)
   );

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         in_mode_ff <= mode_type'(req_tuser);
         in_sx_ff   <= req_tdata[SYM_BITS-1:0];
         in_sy_ff   <= req_tdata[2*SYM_BITS-1:SYM_BITS];
      end
   end

   // Extension state and seed length register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= '0;
         seed_length_ff <= SEED_BITS'(12);
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            seed_length_ff <= csr_data;
         end
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         rsp_payload_ff <= report;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(rsp_payload_ff);
   assign csr_ready  = 1'b1;

   // The peak only falls when a seed opens a new extension.
   `UNGX_ASSERT_NEXT(a_peak_monotonic,
      in_valid_ff && advance && (in_mode_ff != MODE_SEED),
      state_ff.peak_score >= $past(state_ff.peak_score),
      "peak score fell without a seed")

   // A live direction never holds a negative running score.
   `UNGX_ASSERT_HOLDS(a_live_score_nonneg,
      state_ff.direction_stopped || !state_ff.running_score[RUN_BITS-1],
      "negative running score in an active direction")

   // A finish that leaves the request register shows up with the peak score.
   `UNGX_ASSERT_NEXT(a_finish_reports_peak,
      rsp_load,
      rsp_valid_ff && (rsp_payload_ff.best_score == $past(state_ff.peak_score)),
      "finish response missing or wrong score")

   // A held finish keeps the extension state unchanged.
   `UNGX_ASSERT_SAME(a_stall_holds_state,
      in_valid_ff && !advance,
      state_in == state_ff,
      "state moved while a finish was stalled")

endmodule

/* rtl/ungx_step.sv */
// ----------------------------------------------------------------------------
// Ungapped seed extension step
// Scores one request against the current extension state and forms the
// next state and the fragment report.
// ----------------------------------------------------------------------------
module ungx_step (
   input  ungx_pkg::ext_state_type          state_cur,
   input  ungx_pkg::mode_type               mode,
   input  logic [ungx_pkg::SYM_BITS-1:0]    symbol_x,
   input  logic [ungx_pkg::SYM_BITS-1:0]    symbol_y,
   input  logic [ungx_pkg::SEED_BITS-1:0]   seed_length,
   output ungx_pkg::ext_state_type          state_nxt,
   output ungx_pkg::rsp_payload_type        report
);
   import ungx_pkg::*;

   ext_state_type              base;
   logic                       switch_dir;
   logic                       active;
   logic                       is_sep;
   logic                       is_unk;
   logic                       is_match;
   logic signed [RUN_BITS-1:0] run_plus;
   logic signed [RUN_BITS-1:0] run_sat;
   logic signed [RUN_BITS-1:0] run_new;
   logic signed [RUN_BITS-1:0] peak_ext;
   logic [COUNT_BITS-1:0]      match_new;
   logic [OFFSET_BITS:0]       end_sum;
   logic [OFFSET_BITS:0]       start_sum;
   logic [OFFSET_BITS-1:0]     step_new;

   // The first backward pair restarts the walk from the best forward point.
   always_comb begin
      base       = state_cur;
      switch_dir = (mode == MODE_BWD) && !state_cur.in_backward;
      if (switch_dir) begin
         base.in_backward       = 1'b1;
         base.running_score     = RUN_BITS'(state_cur.peak_score);
         base.match_count       = state_cur.peak_match_count;
         base.step_count        = '0;
         base.direction_stopped = 1'b0;
      end
   end

   // Pair classification and the candidate score and counters.
   always_comb begin
      active   = ((mode == MODE_FWD) && !state_cur.in_backward &&
                  !state_cur.direction_stopped) ||
                 ((mode == MODE_BWD) && !base.direction_stopped);
      is_sep   = (symbol_x == SYM_SEP) || (symbol_y == SYM_SEP);
      is_unk   = (symbol_x == SYM_UNK) || (symbol_y == SYM_UNK);
      is_match = (symbol_x == symbol_y);

      peak_ext = RUN_BITS'(state_cur.peak_score);
      run_plus = base.running_score + RUN_BITS'(POINT);
      run_sat  = (run_plus > RUN_BITS'(SCORE_MAX)) ? RUN_BITS'(SCORE_MAX) : run_plus;

      if (is_unk) begin
         run_new = base.running_score - RUN_BITS'(1);
      end else if (is_match) begin
         run_new = run_sat;
      end else begin
         run_new = base.running_score - RUN_BITS'(POINT);
      end

      match_new = (base.match_count == COUNT_MAX) ? base.match_count
                                                  : base.match_count + 1'b1;
      step_new  = (base.step_count == OFFSET_MAX) ? base.step_count
                                                  : base.step_count + 1'b1;
      end_sum   = (OFFSET_BITS + 1)'(seed_length) + (OFFSET_BITS + 1)'(base.step_count);
      start_sum = (OFFSET_BITS + 1)'(base.step_count) + (OFFSET_BITS + 1)'(1);
   end

   // Next state per request mode.
   always_comb begin
      state_nxt = state_cur;
      unique case (mode) inside
         MODE_SEED: begin
            state_nxt.running_score     = RUN_BITS'(seed_length) << POINT_SHIFT;
            state_nxt.peak_score        = SCORE_BITS'(seed_length) << POINT_SHIFT;
            state_nxt.match_count       = COUNT_BITS'(seed_length);
            state_nxt.peak_match_count  = COUNT_BITS'(seed_length);
            state_nxt.step_count        = '0;
            state_nxt.best_end          = OFFSET_BITS'(seed_length);
            state_nxt.best_start        = '0;
            state_nxt.direction_stopped = 1'b0;
            state_nxt.in_backward       = 1'b0;
         end
         MODE_FWD, MODE_BWD: begin
            state_nxt = base;
            if (active) begin
               if (is_sep) begin
                  state_nxt.direction_stopped = 1'b1;
               end else begin
                  state_nxt.running_score = run_new;
                  if (!is_unk && is_match) begin
                     state_nxt.match_count = match_new;
                     // A new peak moves the best point of this direction.
                     if (run_new > peak_ext) begin
                        state_nxt.peak_score       = run_new[SCORE_BITS-1:0];
                        state_nxt.peak_match_count = match_new;
                        if (base.in_backward) begin
                           state_nxt.best_start = sat_offset(start_sum);
                        end else begin
                           state_nxt.best_end = sat_offset(end_sum);
                        end
                     end
                  end
                  state_nxt.step_count = step_new;
                  if (run_new < 0) begin
                     state_nxt.direction_stopped = 1'b1;
                  end
               end
            end
         end
         default: begin
            state_nxt = state_cur;
         end
      endcase
   end

   // Fragment report from the current state.
   always_comb begin
      report.end_offset      = state_cur.best_end;
      report.start_offset    = state_cur.best_start;
      report.fragment_length = (OFFSET_BITS + 1)'(state_cur.best_end) +
                               (OFFSET_BITS + 1)'(state_cur.best_start) +
                               (OFFSET_BITS + 1)'(1);
      report.best_score      = state_cur.peak_score;
      report.identities      = state_cur.peak_match_count;
   end

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// Ungapped seed extension testbench
// Streams seed, forward, backward and finish requests into the block with
// random gaps and receiver stalls. A cycle-free score tracker in the bench
// predicts every reported fragment, and each one is compared field by field.
// A directed table comes first; random extensions follow over several seed
// length settings.
// ----------------------------------------------------------------------------
module tb_top;
   import ungx_pkg::*;

   localparam int IDLE_LIMIT      = 2000;
   localparam int RANDOM_REQUESTS = 1250;
   localparam int PHASES          = 6;
   localparam int SETTLE_CYCLES   = 6;
   localparam int REPORT_LIMIT    = 10;

   typedef struct {
      mode_type              mode;
      logic [SYM_BITS-1:0]   sym_x;
      logic [SYM_BITS-1:0]   sym_y;
      bit                    typed;
      rsp_payload_type       want;
   } stim_row_type;

   // Block inputs start at known values.
   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic [MODE_BITS-1:0]     req_tuser  = '0;
   logic                     rsp_tready = 1'b0;
   logic                     csr_valid  = 1'b0;
   logic [SEED_BITS-1:0]     csr_data   = '0;
   logic                     req_tready;
   logic                     rsp_tvalid;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_ready;

   // Score tracker state and the fragments it still expects.
   ext_state_type        track;
   logic [SEED_BITS-1:0] seed_len;
   rsp_payload_type      fragments_due[$];
   stim_row_type         stim_rows[$];

   int  requests_sent       = 0;
   int  fragments_predicted = 0;
   int  fragments_checked   = 0;
   int  config_writes       = 0;
   int  failures            = 0;
   int  mismatches          = 0;
   int  idle_cycles         = 0;
   bit  push_steady         = 1'b0;
   bit  sink_steady         = 1'b0;

   ungapped_seed_extension dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // symbol_x, symbol_y
      .req_tuser  (req_tuser),   // mode
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      // end_offset, start_offset, fragment_length, best_score, identities
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Scores one symbol pair in the current direction.
   function automatic void score_pair(logic [SYM_BITS-1:0] sx, logic [SYM_BITS-1:0] sy);
      int                   run;
      logic [OFFSET_BITS:0] reach;
      run = $signed(track.running_score);
      if (sx == SYM_SEP || sy == SYM_SEP) begin
         track.direction_stopped = 1'b1;
      end else begin
         if (sx == SYM_UNK || sy == SYM_UNK) begin
            run = run - 1;
         end else if (sx == sy) begin
            run = run + POINT;
            if (run > int'(SCORE_MAX)) begin
               run = int'(SCORE_MAX);
            end
            if (track.match_count != COUNT_MAX) begin
               track.match_count = track.match_count + 1'b1;
            end
            // A new peak moves the best point in the current direction.
            if (run > int'(track.peak_score)) begin
               track.peak_score       = run[SCORE_BITS-1:0];
               track.peak_match_count = track.match_count;
               if (track.in_backward) begin
                  reach = {1'b0, track.step_count} + 1'b1;
                  track.best_start = reach[OFFSET_BITS] ? OFFSET_MAX : reach[OFFSET_BITS-1:0];
               end else begin
                  reach = {1'b0, track.step_count} + (OFFSET_BITS + 1)'(seed_len);
                  track.best_end = reach[OFFSET_BITS] ? OFFSET_MAX : reach[OFFSET_BITS-1:0];
               end
            end
         end else begin
            run = run - POINT;
         end
         if (track.step_count != OFFSET_MAX) begin
            track.step_count = track.step_count + 1'b1;
         end
         track.running_score = run[RUN_BITS-1:0];
         if (run < 0) begin
            track.direction_stopped = 1'b1;
         end
      end
   endfunction

   // Applies one request to the tracker; returns 1 when a fragment is reported.
   function automatic bit predict_request(mode_type m, logic [SYM_BITS-1:0] sx,
                                          logic [SYM_BITS-1:0] sy, output rsp_payload_type frag);
      bit reported;
      reported = 1'b0;
      frag     = '0;
      case (m)
         MODE_SEED: begin
            track.running_score     = RUN_BITS'(POINT * seed_len);
            track.peak_score        = SCORE_BITS'(POINT * seed_len);
            track.match_count       = COUNT_BITS'(seed_len);
            track.peak_match_count  = COUNT_BITS'(seed_len);
            track.step_count        = '0;
            track.best_end          = OFFSET_BITS'(seed_len);
            track.best_start        = '0;
            track.direction_stopped = 1'b0;
            track.in_backward       = 1'b0;
         end
         MODE_FWD: begin
            if (!track.in_backward && !track.direction_stopped) begin
               score_pair(sx, sy);
            end
         end
         MODE_BWD: begin
            // The backward walk restarts from the best forward point.
            if (!track.in_backward) begin
               track.in_backward       = 1'b1;
               track.running_score     = RUN_BITS'(track.peak_score);
               track.match_count       = track.peak_match_count;
               track.step_count        = '0;
               track.direction_stopped = 1'b0;
            end
            if (!track.direction_stopped) begin
               score_pair(sx, sy);
            end
         end
         default: begin
            frag.end_offset      = track.best_end;
            frag.start_offset    = track.best_start;
            frag.fragment_length = {1'b0, track.best_end} + {1'b0, track.best_start} + 1'b1;
            frag.best_score      = track.peak_score;
            frag.identities      = track.peak_match_count;
            reported             = 1'b1;
         end
      endcase
      return reported;
   endfunction

   function automatic rsp_payload_type fragment(int end_off, int start_off, int frag_len,
                                                int score, int ids);
      rsp_payload_type frag;
      frag.end_offset      = OFFSET_BITS'(end_off);
      frag.start_offset    = OFFSET_BITS'(start_off);
      frag.fragment_length = (OFFSET_BITS + 1)'(frag_len);
      frag.best_score      = SCORE_BITS'(score);
      frag.identities      = COUNT_BITS'(ids);
      return frag;
   endfunction

   function automatic void add_row(mode_type m, logic [SYM_BITS-1:0] sx, logic [SYM_BITS-1:0] sy);
      stim_row_type row;
      row.mode  = m;
      row.sym_x = sx;
      row.sym_y = sy;
      row.typed = 1'b0;
      row.want  = '0;
      stim_rows.push_back(row);
   endfunction

   function automatic void add_report(rsp_payload_type want);
      stim_row_type row;
      row.mode  = MODE_FINISH;
      row.sym_x = 8'h00;
      row.sym_y = 8'hFF;
      row.typed = 1'b1;
      row.want  = want;
      stim_rows.push_back(row);
   endfunction

   // Directed requests, written for the reset seed length of 12.
   function automatic void load_directed();
      add_report(fragment(0, 0, 1, 0, 0));       // finish straight after reset
      add_row(MODE_FWD, 8'h41, 8'h41);           // pair before any seed
      add_row(MODE_BWD, 8'h00, 8'hFF);           // backward mismatch before any seed
      add_row(MODE_FINISH, 8'hFF, 8'h00);
      add_row(MODE_SEED, 8'hFF, 8'hFF);
      add_report(fragment(12, 0, 13, 48, 12));   // bare seed
      add_row(MODE_FWD, 8'h00, 8'h00);
      add_row(MODE_FWD, 8'hFF, 8'hFF);
      add_row(MODE_FWD, SYM_UNK, 8'h41);
      add_row(MODE_FWD, 8'h41, SYM_UNK);
      add_row(MODE_FWD, 8'h00, 8'hFF);
      add_row(MODE_FWD, SYM_SEP, 8'h41);         // separator stops the forward walk
      add_row(MODE_FWD, 8'h41, 8'h41);           // ignored after the stop
      add_row(MODE_BWD, 8'hFF, 8'hFF);           // switches direction, then scores
      add_row(MODE_BWD, SYM_UNK, SYM_UNK);
      add_row(MODE_BWD, 8'hAA, 8'h55);
      add_row(MODE_FWD, 8'h41, 8'h41);           // forward pair after backward is ignored
      add_row(MODE_BWD, 8'h41, SYM_SEP);
      add_row(MODE_BWD, 8'h41, 8'h41);
      add_row(MODE_FINISH, 8'h55, 8'hAA);
      add_row(MODE_FINISH, 8'hAA, 8'h55);        // back-to-back finish
      add_row(MODE_SEED, 8'h00, 8'h00);
      add_row(MODE_BWD, 8'h01, 8'h02);           // backward walk with no forward pairs
      add_row(MODE_FINISH, 8'h00, 8'h00);
   endfunction

   // Sender gaps: mostly none, some short, a few long.
   function automatic int draw_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (push_steady || pick < 60) begin
         return 0;
      end else if (pick < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 25);
   endfunction

   // Receiver stalls, shaped like the sender gaps.
   function automatic int draw_stall();
      int pick;
      pick = $urandom_range(0, 99);
      if (sink_steady || pick < 70) begin
         return 0;
      end else if (pick < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 40);
   endfunction

   // Symbol pairs lean toward matches so that walks run long.
   task automatic draw_pair(output logic [SYM_BITS-1:0] sx, output logic [SYM_BITS-1:0] sy);
      int pick;
      pick = $urandom_range(0, 99);
      sx   = SYM_BITS'($urandom_range(0, 255));
      sy   = SYM_BITS'($urandom_range(0, 255));
      if (pick < 70) begin
         sy = sx;
      end else if (pick < 93) begin
         if (pick[0]) sx = SYM_UNK; else sy = SYM_UNK;
      end else if (pick < 97) begin
         if (pick[0]) sx = SYM_SEP; else sy = SYM_SEP;
      end
   endtask

   // Presents one request and waits for it to be taken.
   task automatic send_request(mode_type m, logic [SYM_BITS-1:0] sx, logic [SYM_BITS-1:0] sy,
                               bit typed, rsp_payload_type want);
      int              gap;
      rsp_payload_type frag;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= m;
      req_tdata  <= {sy, sx};
      do @(posedge clock); while (!req_tready);
      requests_sent++;
      if (predict_request(m, sx, sy, frag)) begin
         fragments_due.push_back(typed ? want : frag);
         fragments_predicted++;
      end
   endtask

   // Waits until every fragment is back and the pipeline has emptied.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (fragments_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_seed_length(logic [SEED_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      seed_len = value;
      config_writes++;
      csr_valid <= 1'b0;
   endtask

   // One extension: seed, forward walk, backward walk, finish, with some
   // sequences broken and some plain noise.
   task automatic run_extension();
      int                  fwd_pairs;
      int                  bwd_pairs;
      logic [SYM_BITS-1:0] sx;
      logic [SYM_BITS-1:0] sy;
      push_steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 4)) begin
            send_request(mode_type'($urandom_range(0, 3)), SYM_BITS'($urandom_range(0, 255)),
                         SYM_BITS'($urandom_range(0, 255)), 1'b0, '0);
         end
      end else begin
         if ($urandom_range(0, 11) != 0) begin
            send_request(MODE_SEED, SYM_BITS'($urandom_range(0, 255)),
                         SYM_BITS'($urandom_range(0, 255)), 1'b0, '0);
         end
         fwd_pairs = $urandom_range(0, 20);
         bwd_pairs = $urandom_range(0, 20);
         repeat (fwd_pairs) begin
            draw_pair(sx, sy);
            send_request(MODE_FWD, sx, sy, 1'b0, '0);
         end
         repeat (bwd_pairs) begin
            draw_pair(sx, sy);
            send_request(MODE_BWD, sx, sy, 1'b0, '0);
         end
         if ($urandom_range(0, 11) != 0) begin
            send_request(MODE_FINISH, SYM_BITS'($urandom_range(0, 255)),
                         SYM_BITS'($urandom_range(0, 255)), 1'b0, '0);
         end
      end
   endtask

   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         failures++;
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         end
      end
   endtask

   task automatic check_fragment(rsp_payload_type got);
      rsp_payload_type want;
      if (fragments_due.size() == 0) begin
         failures++;
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: fragment %h arrived with none expected", $time, got);
         end
      end else begin
         want = fragments_due.pop_front();
         fragments_checked++;
         compare_field("end_offset", 32'(want.end_offset), 32'(got.end_offset));
         compare_field("start_offset", 32'(want.start_offset), 32'(got.start_offset));
         compare_field("fragment_length", 32'(want.fragment_length),
                       32'(got.fragment_length));
         compare_field("best_score", 32'(want.best_score), 32'(got.best_score));
         compare_field("identities", 32'(want.identities), 32'(got.identities));
      end
   endtask

   // Receiver: random stalls with occasional steady stretches.
   initial begin : sink
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 149) == 0) begin
            sink_steady = !sink_steady;
         end
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            hold--;
         end else begin
            rsp_tready <= 1'b1;
            hold = draw_stall();
         end
      end
   end

   // Result checker and watchdog.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         check_fragment(rsp_payload_type'(rsp_tdata[RSP_BITS-1:0]));
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no request or fragment moved for %0d cycles", $time, IDLE_LIMIT);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Stimulus: directed table, then random extensions per seed length.
   initial begin : stimulus
      int                   target;
      int                   directed_count;
      logic [SEED_BITS-1:0] setting;
      seed_len = 8'd12;
      track    = '0;
      load_directed();
      directed_count = stim_rows.size();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      foreach (stim_rows[i]) begin
         send_request(stim_rows[i].mode, stim_rows[i].sym_x, stim_rows[i].sym_y,
                      stim_rows[i].typed, stim_rows[i].want);
      end
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: setting = 8'd1;
            1: setting = 8'd255;
            default: setting = SEED_BITS'($urandom_range(1, 255));
         endcase
         settle();
         write_seed_length(setting);
         target = directed_count + (phase + 1) * RANDOM_REQUESTS / PHASES;
         while (requests_sent < target) begin
            run_extension();
         end
      end
      settle();
      $display("Sent %0d requests over %0d seed length writes, seed lengths 1 to 255.",
               requests_sent, config_writes);
      $display("Compared %0d fragments; %0d field mismatches.", fragments_checked, mismatches);
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl
rtl/ungx_pkg.sv
rtl/ungx_step.sv
rtl/ungapped_seed_extension.sv
test/tb_top.sv
